### rtl/core/assert_macros.svh
// Assertion macros for the checker module of this project.
// No dependencies; the file is pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/core/swm_pkg.sv
// Types shared by the sliding window median cells and the top level.
// No dependencies.
package swm_pkg;

   localparam int SAMPLE_W = 16;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // Status that a cell shows to the cell below it.
   typedef struct packed {
      logic valid;
      logic gt_new;
      logic above_del;
   } flags_type;

   // The entry a cell holds once the evicted sample is squeezed out.
   typedef struct packed {
      logic valid;
      logic gt_new;
   } kept_type;

endpackage

### rtl/core/swm_cell.sv
// One cell of the sorted sample chain: a value, its age and a valid bit.
// Depends on swm_pkg; instantiated in a row by sliding_window_median.
module swm_cell import swm_pkg::*; #(
   parameter int AGE_W   = 3,
   parameter int MAX_AGE = 7,
   parameter int INDEX   = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  sample_type       new_sample,
   input  logic             full,
   input  sample_type       del_value,
   input  logic [AGE_W-1:0] sel_index,
   input  sample_type       up_value,
   input  logic [AGE_W-1:0] up_age,
   input  flags_type        up_flags,
   input  sample_type       low_value,
   input  logic [AGE_W-1:0] low_age,
   input  kept_type         low_kept,
   output sample_type       value,
   output logic [AGE_W-1:0] age,
   output flags_type        flags,
   output logic             oldest,
   output sample_type       kept_value,
   output logic [AGE_W-1:0] kept_age,
   output kept_type         kept,
   output sample_type       pick_value
);

   localparam logic [AGE_W-1:0] OLDEST = AGE_W'(MAX_AGE);

   sample_type       value_ff, value_in;
   logic [AGE_W-1:0] age_ff, age_in;
   logic             valid_ff, valid_in;

   always_comb begin
      flags.valid     = valid_ff;
      flags.gt_new    = !valid_ff || (value_ff > new_sample);
      flags.above_del = full && (!valid_ff || (value_ff >= del_value));
   end

   always_comb begin
      if (flags.above_del) begin
         kept_value  = up_value;
         kept_age    = up_age;
         kept.valid  = up_flags.valid;
         kept.gt_new = up_flags.gt_new;
      end else begin
         kept_value  = value_ff;
         kept_age    = age_ff;
         kept.valid  = valid_ff;
         kept.gt_new = flags.gt_new;
      end
   end

   always_comb begin
      if (kept.gt_new) begin
         if (low_kept.gt_new) begin
            value_in = low_value;
            age_in   = low_age + AGE_W'(1);
            valid_in = low_kept.valid;
         end else begin
            value_in = new_sample;
            age_in   = '0;
            valid_in = 1'b1;
         end
      end else begin
         value_in = kept_value;
         age_in   = kept_age + AGE_W'(1);
         valid_in = kept.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

   assign oldest     = full && valid_ff && (age_ff == OLDEST);
   assign value      = value_ff;
   assign age        = age_ff;
   assign pick_value = (sel_index == AGE_W'(INDEX)) ? value_ff : '0;

endmodule

### rtl/core/sliding_window_median.sv
// Running median of the last WINDOW_SIZE signed 16-bit samples, upper median
// when the count is even, over fewer samples during warm-up after reset. The
// samples sit in a sorted chain of cells with age tags; a transaction evicts the
// oldest sample and inserts the new one, and the median is then selected from
// the chain and registered once the output register is free, so the result can
// stall behind a held response; no new sample is accepted until that result is
// registered. Depends on swm_pkg and swm_cell.
module sliding_window_median import swm_pkg::*; #(
   parameter int WINDOW_SIZE = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  sample_type req_sample,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output sample_type rsp_median
);

   localparam int AGE_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int CNT_W = $clog2(WINDOW_SIZE + 1);

   logic [CNT_W-1:0] count_ff;
   logic             pend_ff;
   logic             rsp_valid_ff;
   sample_type       rsp_median_ff;

   logic             accept;
   logic             load_rsp;
   logic             full;
   logic [AGE_W-1:0] sel_index;
   sample_type       del_value;
   sample_type       median;

   sample_type       value_w      [WINDOW_SIZE];
   logic [AGE_W-1:0] age_w        [WINDOW_SIZE];
   flags_type        flags_w      [WINDOW_SIZE];
   logic             oldest_w     [WINDOW_SIZE];
   sample_type       kept_value_w [WINDOW_SIZE];
   logic [AGE_W-1:0] kept_age_w   [WINDOW_SIZE];
   kept_type         kept_w       [WINDOW_SIZE];
   sample_type       pick_w       [WINDOW_SIZE];

   assign accept    = req_valid && req_ready;
   assign load_rsp  = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign full      = (count_ff == CNT_W'(WINDOW_SIZE));
   assign sel_index = AGE_W'(count_ff >> 1);

   always_comb begin
      del_value = '0;
      median    = '0;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         del_value = del_value | (oldest_w[i] ? value_w[i] : sample_type'(0));
         median    = median | pick_w[i];
      end
   end

   for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
      sample_type       up_value;
      logic [AGE_W-1:0] up_age;
      flags_type        up_flags;
      sample_type       low_value;
      logic [AGE_W-1:0] low_age;
      kept_type         low_kept;

      if (i == WINDOW_SIZE - 1) begin : g_top
         assign up_value = '0;
         assign up_age   = '0;
         assign up_flags = '{valid: 1'b0, gt_new: 1'b1, above_del: 1'b1};
      end else begin : g_mid
         assign up_value = value_w[i+1];
         assign up_age   = age_w[i+1];
         assign up_flags = flags_w[i+1];
      end

      if (i == 0) begin : g_bottom
         assign low_value = '0;
         assign low_age   = '0;
         assign low_kept  = '{valid: 1'b0, gt_new: 1'b0};
      end else begin : g_inner
         assign low_value = kept_value_w[i-1];
         assign low_age   = kept_age_w[i-1];
         assign low_kept  = kept_w[i-1];
      end

      swm_cell #(
         .AGE_W   (AGE_W),
         .MAX_AGE (WINDOW_SIZE - 1),
         .INDEX   (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .load       (accept),
         .new_sample (req_sample),
         .full       (full),
         .del_value  (del_value),
         .sel_index  (sel_index),
         .up_value   (up_value),
         .up_age     (up_age),
         .up_flags   (up_flags),
         .low_value  (low_value),
         .low_age    (low_age),
         .low_kept   (low_kept),
         .value      (value_w[i]),
         .age        (age_w[i]),
         .flags      (flags_w[i]),
         .oldest     (oldest_w[i]),
         .kept_value (kept_value_w[i]),
         .kept_age   (kept_age_w[i]),
         .kept       (kept_w[i]),
         .pick_value (pick_w[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept && !full) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (accept) begin
            pend_ff <= 1'b1;
         end else if (load_rsp) begin
            pend_ff <= 1'b0;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_median_ff <= median;
      end
   end

   assign req_ready  = !pend_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

endmodule

### rtl/core/swm_checker.sv
// Port-level assertions for sliding_window_median and the bind that attaches them.
// Depends on swm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swm_checker import swm_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input sample_type req_sample,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input sample_type rsp_median
);

   logic       req_seen_ff;
   logic       rsp_seen_ff;
   sample_type first_sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_seen_ff <= 1'b0;
         rsp_seen_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            req_seen_ff <= 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_seen_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready && !req_seen_ff) begin
         first_sample_ff <= req_sample;
      end
   end

   // A stalled result holds its value.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_median))

   // Only one transaction is in flight at a time.
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // The first result after reset is the first sample itself.
   `ASSERT_IMP(a_first_median, clock, reset, rsp_valid && rsp_ready && !rsp_seen_ff, rsp_median == first_sample_ff)

   // Reset leaves no result pending.
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind sliding_window_median swm_checker u_swm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .req_sample (req_sample),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_median (rsp_median)
);
